// File: hw/rtl/modular_exponentiation_defines.svh
// Assertion helpers for the modular exponentiation RTL.
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define MEXP_ASSERT_CLK(label, clk_sig, rstn_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) \
        else $error(msg);

// Concurrent assertion on the block clock and reset.
`define MEXP_ASSERT(label, prop, msg) \
    `MEXP_ASSERT_CLK(label, clk, rst_n, prop, msg)

`endif

// File: hw/rtl/mexp_pkg.sv
`default_nettype none

package mexp_pkg;

    localparam int unsigned FIELD_BITS     = 31;
    localparam int unsigned EXP_FIELD_BITS = 63;
    localparam logic [FIELD_BITS-1:0] MODULUS_RESET = 31'd1000000007;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_BRED = 6'b000010,
        ST_SKIP = 6'b000100,
        ST_SQR  = 6'b001000,
        ST_MUL  = 6'b010000,
        ST_DONE = 6'b100000
    } mexp_state_t;

endpackage

`default_nettype wire

// File: hw/rtl/modular_exponentiation.sv
// Modular exponentiation, power = base ** exponent mod modulus, by left-to-right
// square and multiply. A single bit-serial modular multiplier does all the work,
// consuming one multiplier bit per cycle. With exponent zero the result (1) goes
// straight to the done state. Otherwise a transaction first reduces the base,
// then skips the leading zero exponent bits, then for each exponent bit from the
// most significant set bit down does a square, plus a multiply when the bit is
// set, and finishes in the done state. A new request is taken only while the
// multiplier is idle; a finished result waits in the output register without
// holding off the next request. The modulus register may be written only while
// no request is in flight; a value of zero acts as 2**MOD_BITS.
`default_nettype none
`include "modular_exponentiation_defines.svh"

module modular_exponentiation
    import mexp_pkg::*;
#(
    parameter int unsigned EXP_BITS = 63,
    parameter int unsigned MOD_BITS = 31
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,

    input  wire logic                      cfg_valid,
    output      logic                      cfg_ready,
    input  wire logic [FIELD_BITS-1:0]     modulus,

    input  wire logic                      req_valid,
    output      logic                      req_stall,
    input  wire logic [FIELD_BITS-1:0]     base,
    input  wire logic [EXP_FIELD_BITS-1:0] exponent,

    output      logic                      rsp_valid,
    input  wire logic                      rsp_stall,
    output      logic [FIELD_BITS-1:0]     power
);

    localparam int unsigned MW = MOD_BITS + 1;
    localparam int unsigned TW = MOD_BITS + 2;
    localparam int unsigned EW = $clog2(EXP_BITS + 1);
    localparam int unsigned CW = $clog2(FIELD_BITS + 1);

    mexp_state_t st_reg, st_next;

    logic [MOD_BITS-1:0]   mod_reg;
    logic [FIELD_BITS-1:0] x_reg, x_next;
    logic [MOD_BITS-1:0]   r_reg, r_next;
    logic [MOD_BITS-1:0]   acc_reg, acc_next;
    logic [MOD_BITS-1:0]   bred_reg, bred_next;
    logic [EXP_BITS-1:0]   e_reg, e_next;
    logic [EW-1:0]         ecnt_reg, ecnt_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    logic [FIELD_BITS-1:0] power_reg, power_next;

    logic [MW-1:0]       m_eff;
    logic [MOD_BITS-1:0] one_red;
    logic [MOD_BITS-1:0] y_sel;
    logic [TW-1:0]       t_sum;
    logic [TW-1:0]       m1;
    logic [TW-1:0]       m2;
    logic [TW-1:0]       t_sub;
    logic [MOD_BITS-1:0] step_res;
    logic                req_acc;
    logic                out_free;
    logic                mul_last;
    logic                e_bit;

    assign m_eff   = (mod_reg == '0) ? (MW'(1) << MOD_BITS) : {1'b0, mod_reg};
    assign one_red = (m_eff == MW'(1)) ? '0 : MOD_BITS'(1);

    always_comb
    begin
        unique case (st_reg)
            ST_BRED: y_sel = one_red;
            ST_SQR:  y_sel = acc_reg;
            default: y_sel = bred_reg;
        endcase
    end

    // r = 2r + xbit*y, then bring below m (at most 3m - 3 before the correction)
    assign t_sum = {1'b0, r_reg, 1'b0} + (x_reg[FIELD_BITS-1] ? TW'(y_sel) : '0);
    assign m1    = TW'(m_eff);
    assign m2    = {m_eff, 1'b0};

    always_comb
    begin
        priority if (t_sum >= m2)
            t_sub = t_sum - m2;
        else if (t_sum >= m1)
            t_sub = t_sum - m1;
        else
            t_sub = t_sum;
    end

    assign step_res = t_sub[MOD_BITS-1:0];

    assign req_stall = (st_reg != ST_IDLE);
    assign req_acc   = req_valid && !req_stall;
    assign cfg_ready = 1'b1;
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign mul_last  = (cnt_reg == CW'(1));
    assign e_bit     = e_reg[EXP_BITS-1];
    assign rsp_valid = rsp_valid_reg;
    assign power     = power_reg;

    always_comb
    begin
        st_next        = st_reg;
        x_next         = x_reg;
        r_next         = r_reg;
        acc_next       = acc_reg;
        bred_next      = bred_reg;
        e_next         = e_reg;
        ecnt_next      = ecnt_reg;
        cnt_next       = cnt_reg;
        rsp_valid_next = rsp_valid_reg;
        power_next     = power_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (st_reg)
            ST_IDLE:
            begin
                if (req_acc)
                begin
                    e_next    = exponent[EXP_BITS-1:0];
                    ecnt_next = EW'(EXP_BITS);
                    if (exponent[EXP_BITS-1:0] == '0)
                    begin
                        acc_next = MOD_BITS'(1);
                        st_next  = ST_DONE;
                    end
                    else
                    begin
                        x_next   = base;
                        r_next   = '0;
                        cnt_next = CW'(FIELD_BITS);
                        st_next  = ST_BRED;
                    end
                end
            end

            ST_BRED:
            begin
                r_next   = step_res;
                x_next   = x_reg << 1;
                cnt_next = cnt_reg - CW'(1);
                if (mul_last)
                begin
                    bred_next = step_res;
                    acc_next  = one_red;
                    st_next   = ST_SKIP;
                end
            end

            ST_SKIP:
            begin
                if (e_bit)
                begin
                    x_next   = FIELD_BITS'(acc_reg) << (FIELD_BITS - MOD_BITS);
                    r_next   = '0;
                    cnt_next = CW'(MOD_BITS);
                    st_next  = ST_SQR;
                end
                else
                begin
                    e_next    = e_reg << 1;
                    ecnt_next = ecnt_reg - EW'(1);
                end
            end

            ST_SQR, ST_MUL:
            begin
                r_next   = step_res;
                x_next   = x_reg << 1;
                cnt_next = cnt_reg - CW'(1);
                if (mul_last)
                begin
                    acc_next = step_res;
                    r_next   = '0;
                    cnt_next = CW'(MOD_BITS);
                    x_next   = FIELD_BITS'(step_res) << (FIELD_BITS - MOD_BITS);
                    if (st_reg == ST_SQR && e_bit)
                    begin
                        st_next = ST_MUL;
                    end
                    else if (ecnt_reg == EW'(1))
                    begin
                        st_next = ST_DONE;
                    end
                    else
                    begin
                        e_next    = e_reg << 1;
                        ecnt_next = ecnt_reg - EW'(1);
                        st_next   = ST_SQR;
                    end
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    power_next     = FIELD_BITS'(acc_reg);
                    rsp_valid_next = 1'b1;
                    st_next        = ST_IDLE;
                end
            end

            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            mod_reg       <= MODULUS_RESET[MOD_BITS-1:0];
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                mod_reg <= modulus[MOD_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        r_reg     <= r_next;
        acc_reg   <= acc_next;
        bred_reg  <= bred_next;
        e_reg     <= e_next;
        ecnt_reg  <= ecnt_next;
        cnt_reg   <= cnt_next;
        power_reg <= power_next;
    end

    `MEXP_ASSERT(a_acc_reduced,
        (st_reg == ST_SQR || st_reg == ST_MUL) |-> (MW'(acc_reg) < m_eff),
        "accumulator not reduced during multiply")

    `MEXP_ASSERT(a_partial_reduced,
        (st_reg == ST_SQR || st_reg == ST_MUL || st_reg == ST_BRED) |-> (MW'(r_reg) < m_eff),
        "partial product not reduced")

    `MEXP_ASSERT(a_cnt_live,
        (st_reg == ST_SQR || st_reg == ST_MUL || st_reg == ST_BRED) |-> (cnt_reg != '0),
        "multiplier bit count exhausted")

    `MEXP_ASSERT(a_rsp_from_done,
        $rose(rsp_valid_reg) |-> $past(st_reg == ST_DONE),
        "response raised outside completion")

endmodule

`default_nettype wire

// File: bench/tb_modular_exponentiation.sv
`timescale 1ns / 1ps

module tb_modular_exponentiation;
    import mexp_pkg::*;

    localparam int unsigned MOD_WIDTH   = 31;
    localparam int unsigned CYCLE_LIMIT = 4000000;
    localparam int unsigned MAX_REPORTS = 10;

    typedef struct {
        logic [FIELD_BITS-1:0]     base;
        logic [EXP_FIELD_BITS-1:0] exponent;
        logic [FIELD_BITS-1:0]     power;
    } power_expect_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [FIELD_BITS-1:0]     modulus;
    logic                      req_valid;
    logic                      req_stall;
    logic [FIELD_BITS-1:0]     base;
    logic [EXP_FIELD_BITS-1:0] exponent;
    logic                      rsp_valid;
    logic                      rsp_stall;
    logic [FIELD_BITS-1:0]     power;

    power_expect_t         expected_powers[$];
    logic [FIELD_BITS-1:0] mod_setting;
    bit                    idle_en;
    int                    mismatches  = 0;
    int                    hold_cycles = 0;
    int                    stall_left  = 0;

    modular_exponentiation #(
        .EXP_BITS (63),
        .MOD_BITS (31)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .modulus   (modulus),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .base      (base),
        .exponent  (exponent),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .power     (power)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Timeout after %0d cycles, %0d results outstanding",
                 CYCLE_LIMIT, expected_powers.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [63:0] mod_mul(input logic [63:0] x, input logic [63:0] y,
                                             input logic [63:0] m);
        logic [63:0] p;
        p = x * y;
        if (p >= m)
            p = p % m;
        return p;
    endfunction

    // left-to-right square and multiply, reducing only when product >= m
    function automatic logic [FIELD_BITS-1:0] predict_power(
        input logic [FIELD_BITS-1:0]     b,
        input logic [EXP_FIELD_BITS-1:0] e,
        input logic [FIELD_BITS-1:0]     m_set
    );
        logic [63:0] m;
        logic [63:0] acc;
        bit          started;
        m = 64'(m_set);
        if (m == 64'd0)
            m = 64'd1 << MOD_WIDTH;
        acc = 64'd1;
        started = 1'b0;
        for (int i = EXP_FIELD_BITS - 1; i >= 0; i--)
        begin
            if (!started && !e[i])
                continue;
            started = 1'b1;
            acc = mod_mul(acc, acc, m);
            if (e[i])
                acc = mod_mul(acc, 64'(b), m);
        end
        return acc[FIELD_BITS-1:0];
    endfunction

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(15, 80);
    endfunction

    task automatic check_power(input logic [FIELD_BITS-1:0] got);
        power_expect_t exp_item;
        if (expected_powers.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: unexpected result transaction, power=%0d", $realtime, got);
        end
        else
        begin
            exp_item = expected_powers.pop_front();
            if (got !== exp_item.power)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: power mismatch base=%0d exponent=%0h: expected %0d, got %0d",
                             $realtime, exp_item.base, exp_item.exponent, exp_item.power, got);
            end
        end
    endtask

    // response side: checks results and drives stall
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            check_power(power);
        if (hold_cycles > 0)
        begin
            rsp_stall   <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else if (stall_left > 0)
        begin
            rsp_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (!idle_en || $urandom_range(0, 3) != 0)
        begin
            rsp_stall <= 1'b0;
        end
        else
        begin
            rsp_stall  <= 1'b1;
            stall_left <= idle_len();
        end
    end

    task automatic send_operands(input logic [FIELD_BITS-1:0] b,
                                 input logic [EXP_FIELD_BITS-1:0] e);
        power_expect_t exp_item;
        int unsigned   gap;
        gap = idle_en ? idle_len() : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        base      <= b;
        exponent  <= e;
        do
            @(posedge clk);
        while (req_stall);
        exp_item.base     = b;
        exp_item.exponent = e;
        exp_item.power    = predict_power(b, e, mod_setting);
        expected_powers   = {expected_powers, exp_item};
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (expected_powers.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_modulus(input logic [FIELD_BITS-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        modulus   <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid   <= 1'b0;
        mod_setting = value;
    endtask

    function automatic logic [FIELD_BITS-1:0] random_base();
        int unsigned r;
        r = $urandom_range(0, 9);
        case (r)
            0: return '0;
            1: return 31'd1;
            2: return mod_setting - 31'd1;
            3: return '1;
            4, 5, 6: return FIELD_BITS'($urandom());
            default:
                if (mod_setting >= 31'd2)
                    return FIELD_BITS'($urandom_range(0, mod_setting - 1));
                else
                    return FIELD_BITS'($urandom());
        endcase
    endfunction

    // most exponents are masked to a random width to keep the run time down
    function automatic logic [EXP_FIELD_BITS-1:0] random_exponent();
        int unsigned         r;
        int unsigned         w;
        logic [63:0]         raw;
        r   = $urandom_range(0, 19);
        raw = {$urandom(), $urandom()};
        case (r)
            0: return '0;
            1: return EXP_FIELD_BITS'($urandom_range(1, 3));
            2: return '1;
            3, 4, 5, 6, 7, 8: return raw[EXP_FIELD_BITS-1:0];
            default:
            begin
                w = $urandom_range(1, EXP_FIELD_BITS);
                return EXP_FIELD_BITS'(raw & ((64'd1 << w) - 64'd1));
            end
        endcase
    endfunction

    task automatic test_reset_modulus();
        send_operands(31'd0, 63'd0);
        send_operands(31'd5, 63'd0);
        send_operands(31'd2, 63'd10);
        send_operands('1, 63'd1);
        send_operands(31'd0, 63'd5);
        send_operands('1, 63'd3);
        send_operands(31'd1, '1);
        send_operands(31'd3, 63'd1 << 62);
        send_operands(31'h2AAAAAAA, 63'h5555555555555555);
        send_operands(31'h55555555, 63'h2AAAAAAAAAAAAAAA);
        wait_drained();
    endtask

    task automatic test_modulus_extremes();
        write_modulus(31'd2);
        send_operands(31'd3, 63'd7);
        send_operands('1, '1);
        send_operands(31'd4, 63'd0);
        write_modulus('1);
        send_operands('1, 63'd2);
        send_operands(31'h7FFFFFFE, '1);
        send_operands(31'd12345, 63'h7FFFFFFFFFFFFFFE);
        write_modulus(31'd1);
        send_operands(31'd9, 63'd0);
        send_operands(31'd9, 63'd4);
        write_modulus(31'd0);
        send_operands(31'd3, 63'd40);
        send_operands('1, 63'd17);
        send_operands(31'd2, 63'd31);
        write_modulus(MODULUS_RESET);
        send_operands(31'd2, 63'd1000000006);
        wait_drained();
    endtask

    task automatic test_backpressure();
        idle_en = 1'b0;
        hold_cycles <= 400;
        for (int i = 0; i < 10; i++)
            send_operands(FIELD_BITS'($urandom()), EXP_FIELD_BITS'($urandom_range(0, 7)));
        wait_drained();
        idle_en = 1'b1;
    endtask

    task automatic test_random_operands();
        logic [FIELD_BITS-1:0] m;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: m = MODULUS_RESET;
                1: m = FIELD_BITS'($urandom_range(2, 1000));
                2: m = FIELD_BITS'($urandom_range(2, 32'h7FFFFFFF));
                default: m = FIELD_BITS'($urandom());
            endcase
            write_modulus(m);
            idle_en = (phase != 1);
            for (int i = 0; i < 28; i++)
                send_operands(random_base(), random_exponent());
        end
        wait_drained();
        idle_en = 1'b1;
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        modulus     = MODULUS_RESET;
        req_valid   = 1'b0;
        base        = '0;
        exponent    = '0;
        rsp_stall   = 1'b0;
        mod_setting = MODULUS_RESET;
        idle_en     = 1'b1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_modulus();
        test_modulus_extremes();
        test_backpressure();
        test_random_operands();

        wait_drained();
        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/mexp_pkg.sv
hw/rtl/modular_exponentiation.sv
bench/tb_modular_exponentiation.sv
